// ===== design/pcf_pkg.sv =====
// ----------------------------------------------------------------------------
// pcf_pkg
// Shared types and codes for the cohesive pair force block: arithmetic unit
// operations, sequencer steps, controller/datapath command and status.
// ----------------------------------------------------------------------------
package pcf_pkg;

    typedef logic [1:0] t_op;
    localparam t_op OP_MUL  = 2'd0;
    localparam t_op OP_DIV  = 2'd1;
    localparam t_op OP_SQRT = 2'd2;

    typedef logic [1:0] t_regime;
    localparam t_regime REG_NONE  = 2'd0;
    localparam t_regime REG_PULL  = 2'd1;
    localparam t_regime REG_VDW   = 2'd2;
    localparam t_regime REG_FAULT = 2'd3;

    // sequencer steps, in execution order
    typedef logic [4:0] t_step;
    localparam t_step SP_SQ0   = 5'd0;
    localparam t_step SP_SQ1   = 5'd1;
    localparam t_step SP_SQ2   = 5'd2;
    localparam t_step SP_DSQRT = 5'd3;
    localparam t_step SP_RPROD = 5'd4;
    localparam t_step SP_REFF  = 5'd5;
    localparam t_step SP_AR    = 5'd6;
    localparam t_step SP_GR    = 5'd7;
    localparam t_step SP_PULL  = 5'd8;
    localparam t_step SP_PDEN  = 5'd9;
    localparam t_step SP_LQ    = 5'd10;
    localparam t_step SP_LIM   = 5'd11;
    localparam t_step SP_ROOT  = 5'd12;
    localparam t_step SP_CUT   = 5'd13;
    localparam t_step SP_GG    = 5'd14;
    localparam t_step SP_GDEN  = 5'd15;
    localparam t_step SP_VDW   = 5'd16;
    localparam t_step SP_CM0   = 5'd17;
    localparam t_step SP_CD0   = 5'd18;
    localparam t_step SP_CM1   = 5'd19;
    localparam t_step SP_CD1   = 5'd20;
    localparam t_step SP_CM2   = 5'd21;
    localparam t_step SP_CD2   = 5'd22;

    typedef struct packed {
        logic  load;
        logic  start;
        logic  commit;
        logic  finish;
        t_step step;
    } t_cmd;

    typedef struct packed {
        logic arith_done;
        logic same;
        logic zero_dist;
        logic rsum_zero;
        logic pull_zero;
        logic decline_zero;
        logic in_cutoff;
        logic at_limit;
    } t_stat;

endpackage

// ===== design/pcf_arith.sv =====
// ----------------------------------------------------------------------------
// pcf_arith
// Shared iterative unit: 128x64 multiply from 32x32 partial products,
// restoring 128-bit divide one bit a cycle, 128-bit integer square root
// two bits a cycle.
// ----------------------------------------------------------------------------
module pcf_arith (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  pcf_pkg::t_op   i_op,
    input  logic [127:0]   i_a,
    input  logic [127:0]   i_b,
    output logic           o_done,
    output logic [127:0]   o_res
);
    import pcf_pkg::*;

    logic         r_busy;
    logic         r_done;
    t_op          r_op;
    logic [6:0]   r_cnt;
    logic [127:0] r_a;
    logic [127:0] r_b;
    logic [127:0] r_acc;
    logic [127:0] r_rem;
    logic [63:0]  r_pp;
    logic [2:0]   r_sh;
    logic [63:0]  r_root;
    logic [67:0]  r_srem;

    logic         w_last;
    logic [31:0]  w_ach;
    logic [31:0]  w_bch;
    logic [127:0] w_ppsh;
    logic [127:0] w_dsh;
    logic         w_dge;
    logic [67:0]  w_ssh;
    logic [67:0]  w_trial;
    logic         w_sge;

    always_comb begin
        case (r_op)
            OP_MUL:  w_last = (r_cnt == 7'd8);
            OP_DIV:  w_last = (r_cnt == 7'd127);
            OP_SQRT: w_last = (r_cnt == 7'd63);
            default: w_last = 1'b1;
        endcase
    end

    assign w_ach   = r_a[{r_cnt[1:0], 5'b0} +: 32];
    assign w_bch   = r_b[{r_cnt[2], 5'b0} +: 32];
    assign w_ppsh  = {64'b0, r_pp} << {r_sh, 5'b0};

    assign w_dsh   = {r_rem[126:0], r_a[127]};
    assign w_dge   = (w_dsh >= r_b);

    assign w_ssh   = {r_srem[65:0], r_a[127:126]};
    assign w_trial = {2'b0, r_root, 2'b01};
    assign w_sge   = (w_ssh >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= OP_MUL;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_op   <= i_op;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 7'd1;
                if (w_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a    <= i_a;
            r_b    <= i_b;
            r_acc  <= '0;
            r_rem  <= '0;
            r_root <= '0;
            r_srem <= '0;
        end else if (r_busy) begin
            case (r_op)
                OP_MUL: begin
                    // product registered the cycle before the add
                    if (!r_cnt[3]) begin
                        r_pp <= 64'(w_ach) * 64'(w_bch);
                        r_sh <= {1'b0, r_cnt[1:0]} + {2'b0, r_cnt[2]};
                    end
                    if (r_cnt != 7'd0) begin
                        r_acc <= r_acc + w_ppsh;
                    end
                end
                OP_DIV: begin
                    r_rem <= w_dge ? (w_dsh - r_b) : w_dsh;
                    r_a   <= {r_a[126:0], 1'b0};
                    r_acc <= {r_acc[126:0], w_dge};
                end
                OP_SQRT: begin
                    r_srem <= w_sge ? (w_ssh - w_trial) : w_ssh;
                    r_root <= {r_root[62:0], w_sge};
                    r_a    <= {r_a[125:0], 2'b0};
                end
                default: ;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_res  = (r_op == OP_SQRT) ? {64'b0, r_root} : r_acc;

endmodule

// ===== design/pcf_ctrl.sv =====
// ----------------------------------------------------------------------------
// pcf_ctrl
// Sequencer for one pair: walks the arithmetic steps, skips those that the
// special cases make moot, and owns both channel handshakes.
// ----------------------------------------------------------------------------
module pcf_ctrl #(
    parameter int DIMENSIONS = 3
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    output logic            o_valid,
    input  logic            i_ready,
    input  pcf_pkg::t_stat  i_stat,
    output pcf_pkg::t_cmd   o_cmd
);
    import pcf_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_WAIT  = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    t_step      r_step;
    t_step      n_step;
    logic       r_ovalid;

    logic w_skip;
    logic w_early;
    logic w_tocm;

    always_comb begin
        w_skip  = 1'b0;
        w_early = 1'b0;
        w_tocm  = 1'b0;
        case (r_step)
            SP_SQ1, SP_CM1, SP_CD1:  w_skip = (DIMENSIONS < 2);
            SP_SQ2, SP_CM2, SP_CD2:  w_skip = (DIMENSIONS < 3);
            SP_DSQRT:                w_early = i_stat.same | i_stat.zero_dist;
            SP_REFF:                 w_skip = i_stat.rsum_zero;
            SP_PDEN, SP_LQ, SP_LIM:  w_skip = i_stat.pull_zero;
            SP_ROOT, SP_CUT:         w_skip = i_stat.pull_zero | i_stat.decline_zero;
            SP_GG: begin
                w_early = !i_stat.in_cutoff;
                w_tocm  = i_stat.at_limit;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        o_cmd.step = r_step;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_step     = SP_SQ0;
                    n_state    = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (w_early) begin
                    n_state = ST_OUT;
                end else if (w_tocm) begin
                    n_step = SP_CM0;
                end else if (w_skip) begin
                    if (r_step == SP_CD2) begin
                        n_state = ST_OUT;
                    end else begin
                        n_step = r_step + 5'd1;
                    end
                end else begin
                    o_cmd.start = 1'b1;
                    n_state     = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (i_stat.arith_done) begin
                    o_cmd.commit = 1'b1;
                    if (r_step == SP_CD2) begin
                        n_state = ST_OUT;
                    end else begin
                        n_step  = r_step + 5'd1;
                        n_state = ST_ISSUE;
                    end
                end
            end
            ST_OUT: begin
                // result register frees up on the beat that drains it
                if (!r_ovalid || i_ready) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_step   <= SP_SQ0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            if (o_cmd.finish) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = r_ovalid;

endmodule

// ===== design/pcf_datapath.sv =====
// ----------------------------------------------------------------------------
// pcf_datapath
// Pair registers, operand selection for the shared arithmetic unit,
// per-owner accumulators, configuration registers and the result register.
// ----------------------------------------------------------------------------
module pcf_datapath #(
    parameter int DIMENSIONS = 3
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pcf_pkg::t_cmd        i_cmd,
    output pcf_pkg::t_stat       o_stat,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [47:0]          i_cfg_data,
    input  logic signed [47:0]   i_own_pos_x,
    input  logic signed [47:0]   i_own_pos_y,
    input  logic signed [47:0]   i_own_pos_z,
    input  logic signed [47:0]   i_partner_pos_x,
    input  logic signed [47:0]   i_partner_pos_y,
    input  logic signed [47:0]   i_partner_pos_z,
    input  logic [39:0]          i_own_radius,
    input  logic [39:0]          i_partner_radius,
    input  logic [31:0]          i_own_ident,
    input  logic [31:0]          i_partner_ident,
    input  logic                 i_last_partner,
    output logic signed [63:0]   o_pair_force_x,
    output logic signed [63:0]   o_pair_force_y,
    output logic signed [63:0]   o_pair_force_z,
    output pcf_pkg::t_regime     o_pair_regime,
    output logic signed [63:0]   o_total_force_x,
    output logic signed [63:0]   o_total_force_y,
    output logic signed [63:0]   o_total_force_z,
    output logic                 o_total_valid
);
    import pcf_pkg::*;

    localparam logic [1:0]  CFG_HAMAKER = 2'd0;
    localparam logic [1:0]  CFG_SURFACE = 2'd1;
    localparam logic [1:0]  CFG_DECLINE = 2'd2;
    localparam logic [35:0] FOUR_PI_Q32 = 36'hC90FDAA22;
    localparam logic [63:0] SAT_U64     = '1;

    function automatic logic [63:0] sat64(input logic [127:0] v);
        return (v[127:64] != 64'd0) ? SAT_U64 : v[63:0];
    endfunction

    function automatic logic signed [63:0] signed_comp(input logic [127:0] q,
                                                       input logic neg);
        logic [63:0] c;
        c = sat64(q);
        if (c[63]) begin
            return neg ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
        end
        return neg ? -$signed(c) : $signed(c);
    endfunction

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s[64] != s[63]) begin
            return s[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
        end
        return s[63:0];
    endfunction

    // configuration
    logic [47:0] r_ham;
    logic [47:0] r_surf;
    logic [32:0] r_decline;

    // working registers for the pair in flight
    logic signed [48:0] r_d [3];
    logic [39:0]        r_r1;
    logic [39:0]        r_r2;
    logic [40:0]        r_rsum;
    logic               r_same;
    logic               r_last;
    logic [97:0]        r_dist2;
    logic [49:0]        r_dist;
    logic signed [51:0] r_gap;
    logic [127:0]       r_tmp;
    logic [39:0]        r_reff;
    logic [87:0]        r_ar;
    logic [63:0]        r_pull;
    logic [63:0]        r_limit;
    logic [63:0]        r_cutoff;
    logic [63:0]        r_vdw;
    logic signed [63:0] r_f [3];
    logic signed [63:0] r_sum [3];

    // result register
    logic signed [63:0] r_pf [3];
    logic signed [63:0] r_tot [3];
    t_regime            r_regime;
    logic               r_tval;

    logic signed [48:0] w_d [3];
    logic [48:0]        w_abs [3];
    logic signed [63:0] w_sum [3];
    logic [39:0]        w_reff;
    logic [63:0]        w_limit;
    logic [63:0]        w_cutoff;
    logic [63:0]        w_gap_u;
    logic               w_gap_neg;
    logic               w_in_cutoff;
    logic               w_at_limit;
    logic [63:0]        w_mag;
    t_regime            w_regime;
    t_op                w_op;
    logic [127:0]       w_a;
    logic [127:0]       w_b;
    logic               w_done;
    logic [127:0]       w_res;

    assign w_d[0] = 49'(i_partner_pos_x) - 49'(i_own_pos_x);
    assign w_d[1] = (DIMENSIONS >= 2) ? 49'(i_partner_pos_y) - 49'(i_own_pos_y) : '0;
    assign w_d[2] = (DIMENSIONS >= 3) ? 49'(i_partner_pos_z) - 49'(i_own_pos_z) : '0;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_abs[k] = r_d[k][48] ? 49'(-r_d[k]) : 49'(r_d[k]);
            w_sum[k] = sat_add(r_sum[k], r_f[k]);
        end
    end

    assign w_reff      = (r_rsum == '0) ? '0 : r_reff;
    assign w_limit     = (r_pull == '0) ? SAT_U64 : r_limit;
    assign w_cutoff    = ((r_pull == '0) || (r_decline == '0)) ? SAT_U64 : r_cutoff;
    assign w_gap_neg   = r_gap[51];
    assign w_gap_u     = 64'($unsigned(r_gap));
    assign w_in_cutoff = w_gap_neg || (w_gap_u < w_cutoff);
    assign w_at_limit  = w_gap_neg || (w_gap_u <= w_limit);
    assign w_mag       = w_at_limit ? r_pull : r_vdw;

    always_comb begin
        if (r_same) begin
            w_regime = REG_NONE;
        end else if (r_dist2 == '0) begin
            w_regime = REG_FAULT;
        end else if (!w_in_cutoff) begin
            w_regime = REG_NONE;
        end else if (w_at_limit) begin
            w_regime = REG_PULL;
        end else begin
            w_regime = REG_VDW;
        end
    end

    // operand select for the shared unit
    always_comb begin
        w_op = OP_MUL;
        w_a  = '0;
        w_b  = '0;
        case (i_cmd.step)
            SP_SQ0:   begin w_a = 128'(w_abs[0]); w_b = 128'(w_abs[0]); end
            SP_SQ1:   begin w_a = 128'(w_abs[1]); w_b = 128'(w_abs[1]); end
            SP_SQ2:   begin w_a = 128'(w_abs[2]); w_b = 128'(w_abs[2]); end
            SP_DSQRT: begin w_op = OP_SQRT; w_a = 128'(r_dist2); end
            SP_RPROD: begin w_a = 128'(r_r1); w_b = 128'(r_r2); end
            SP_REFF:  begin w_op = OP_DIV; w_a = r_tmp; w_b = 128'(r_rsum); end
            SP_AR:    begin w_a = 128'(r_ham); w_b = 128'(w_reff); end
            SP_GR:    begin w_a = 128'(r_surf); w_b = 128'(w_reff); end
            SP_PULL:  begin w_a = r_tmp; w_b = 128'(FOUR_PI_Q32); end
            SP_PDEN:  begin w_a = 128'(r_pull); w_b = 128'd6; end
            SP_LQ:    begin w_op = OP_DIV; w_a = 128'({r_ar, 24'b0}); w_b = r_tmp; end
            SP_LIM:   begin w_op = OP_SQRT; w_a = r_tmp; end
            SP_ROOT:  begin w_op = OP_SQRT; w_a = 128'({r_decline, 32'b0}); end
            SP_CUT:   begin w_op = OP_DIV; w_a = 128'({r_limit, 32'b0}); w_b = r_tmp; end
            SP_GG:    begin w_a = 128'(w_gap_u); w_b = 128'(w_gap_u); end
            SP_GDEN:  begin w_a = r_tmp; w_b = 128'd6; end
            SP_VDW:   begin w_op = OP_DIV; w_a = 128'({r_ar, 24'b0}); w_b = r_tmp; end
            SP_CM0:   begin w_a = 128'(w_mag); w_b = 128'(w_abs[0]); end
            SP_CM1:   begin w_a = 128'(w_mag); w_b = 128'(w_abs[1]); end
            SP_CM2:   begin w_a = 128'(w_mag); w_b = 128'(w_abs[2]); end
            SP_CD0, SP_CD1, SP_CD2: begin
                w_op = OP_DIV;
                w_a  = r_tmp;
                w_b  = 128'(r_dist);
            end
            default: ;
        endcase
    end

    pcf_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.start),
        .i_op    (w_op),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_done  (w_done),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int k = 0; k < 3; k++) begin
                r_d[k] <= w_d[k];
                r_f[k] <= '0;
            end
            r_r1    <= i_own_radius;
            r_r2    <= i_partner_radius;
            r_rsum  <= 41'(i_own_radius) + 41'(i_partner_radius);
            r_same  <= (i_own_ident == i_partner_ident);
            r_last  <= i_last_partner;
            r_dist2 <= '0;
        end else if (i_cmd.commit) begin
            case (i_cmd.step)
                SP_SQ0, SP_SQ1, SP_SQ2: r_dist2 <= r_dist2 + w_res[97:0];
                SP_DSQRT: begin
                    r_dist <= w_res[49:0];
                    r_gap  <= $signed({2'b0, w_res[49:0]}) - $signed({11'b0, r_rsum});
                end
                SP_REFF:  r_reff   <= w_res[39:0];
                SP_AR:    r_ar     <= w_res[87:0];
                SP_PULL:  r_pull   <= (w_res[127:120] != '0) ? SAT_U64 : w_res[119:56];
                SP_LIM:   r_limit  <= w_res[63:0];
                SP_CUT:   r_cutoff <= sat64(w_res);
                SP_VDW:   r_vdw    <= sat64(w_res);
                SP_CD0:   r_f[0]   <= signed_comp(w_res, r_d[0][48]);
                SP_CD1:   r_f[1]   <= signed_comp(w_res, r_d[1][48]);
                SP_CD2:   r_f[2]   <= signed_comp(w_res, r_d[2][48]);
                default:  r_tmp    <= w_res;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            for (int k = 0; k < 3; k++) begin
                r_pf[k]  <= r_f[k];
                r_tot[k] <= r_last ? w_sum[k] : '0;
            end
            r_regime <= w_regime;
            r_tval   <= r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ham     <= '0;
            r_surf    <= '0;
            r_decline <= 33'h1_0000_0000;
            for (int k = 0; k < 3; k++) begin
                r_sum[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_HAMAKER: r_ham     <= i_cfg_data;
                    CFG_SURFACE: r_surf    <= i_cfg_data;
                    CFG_DECLINE: r_decline <= i_cfg_data[32:0];
                    default: ;
                endcase
            end
            if (i_cmd.finish) begin
                for (int k = 0; k < 3; k++) begin
                    r_sum[k] <= r_last ? '0 : w_sum[k];
                end
            end
        end
    end

    assign o_stat.arith_done   = w_done;
    assign o_stat.same         = r_same;
    assign o_stat.zero_dist    = (r_dist2 == '0);
    assign o_stat.rsum_zero    = (r_rsum == '0);
    assign o_stat.pull_zero    = (r_pull == '0);
    assign o_stat.decline_zero = (r_decline == '0);
    assign o_stat.in_cutoff    = w_in_cutoff;
    assign o_stat.at_limit     = w_at_limit;

    assign o_pair_force_x  = r_pf[0];
    assign o_pair_force_y  = r_pf[1];
    assign o_pair_force_z  = r_pf[2];
    assign o_pair_regime   = r_regime;
    assign o_total_force_x = r_tot[0];
    assign o_total_force_y = r_tot[1];
    assign o_total_force_z = r_tot[2];
    assign o_total_valid   = r_tval;

endmodule

// ===== design/particle_cohesive_force.sv =====
// ----------------------------------------------------------------------------
// particle_cohesive_force
// Cohesive (van der Waals with pull-off limit) pair force and per-owner sum.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_ready) takes one owner/partner pair per beat.
//   Output channel (o_valid/i_ready) returns one result beat per pair: the
//   pair force, its regime and, on the pair marked last, the owner's totals.
//   Pairs are processed one at a time by a single shared multiply / divide /
//   square-root unit. A pair in the van der Waals regime runs the longest step
//   sequence; same-identity and coincident pairs end after the squared distance,
//   and pairs outside the cut-off end before the force steps. The next pair is
//   accepted as soon as the previous one has moved into the result register.
//   If the receiver stalls, the finished pair waits in the sequencer until
//   the result register drains; the input stays closed meanwhile.
//   Reset (synchronous, active low) clears the accumulators, loads register
//   defaults and empties the result register. Configuration writes take effect
//   on the edge where i_cfg_we is high; the user must issue them only while idle, as the block does not enforce it.
// ----------------------------------------------------------------------------
module particle_cohesive_force #(
    parameter int DIMENSIONS = 3
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [47:0]          i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [47:0]   i_own_pos_x,
    input  logic signed [47:0]   i_own_pos_y,
    input  logic signed [47:0]   i_own_pos_z,
    input  logic signed [47:0]   i_partner_pos_x,
    input  logic signed [47:0]   i_partner_pos_y,
    input  logic signed [47:0]   i_partner_pos_z,
    input  logic [39:0]          i_own_radius,
    input  logic [39:0]          i_partner_radius,
    input  logic [31:0]          i_own_ident,
    input  logic [31:0]          i_partner_ident,
    input  logic                 i_last_partner,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [63:0]   o_pair_force_x,
    output logic signed [63:0]   o_pair_force_y,
    output logic signed [63:0]   o_pair_force_z,
    output logic [1:0]           o_pair_regime,
    output logic signed [63:0]   o_total_force_x,
    output logic signed [63:0]   o_total_force_y,
    output logic signed [63:0]   o_total_force_z,
    output logic                 o_total_valid
);
    import pcf_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    pcf_ctrl #(.DIMENSIONS(DIMENSIONS)) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    pcf_datapath #(.DIMENSIONS(DIMENSIONS)) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_own_pos_x      (i_own_pos_x),
        .i_own_pos_y      (i_own_pos_y),
        .i_own_pos_z      (i_own_pos_z),
        .i_partner_pos_x  (i_partner_pos_x),
        .i_partner_pos_y  (i_partner_pos_y),
        .i_partner_pos_z  (i_partner_pos_z),
        .i_own_radius     (i_own_radius),
        .i_partner_radius (i_partner_radius),
        .i_own_ident      (i_own_ident),
        .i_partner_ident  (i_partner_ident),
        .i_last_partner   (i_last_partner),
        .o_pair_force_x   (o_pair_force_x),
        .o_pair_force_y   (o_pair_force_y),
        .o_pair_force_z   (o_pair_force_z),
        .o_pair_regime    (o_pair_regime),
        .o_total_force_x  (o_total_force_x),
        .o_total_force_y  (o_total_force_y),
        .o_total_force_z  (o_total_force_z),
        .o_total_valid    (o_total_valid)
    );

endmodule

// ===== design/pcf_check.sv =====
// ----------------------------------------------------------------------------
// pcf_check
// Port-level checks for the cohesive pair force block, bound to the top.
// ----------------------------------------------------------------------------
module pcf_check (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_ready,
    input logic                o_valid,
    input logic                i_ready,
    input logic signed [63:0]  o_pair_force_x,
    input logic signed [63:0]  o_pair_force_y,
    input logic signed [63:0]  o_pair_force_z,
    input logic [1:0]          o_pair_regime,
    input logic signed [63:0]  o_total_force_x,
    input logic signed [63:0]  o_total_force_y,
    input logic signed [63:0]  o_total_force_z,
    input logic                o_total_valid
);
    import pcf_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_pair_force_x) && $stable(o_total_force_x)
            && $stable(o_pair_regime) && $stable(o_total_valid))
        else $error("result payload changed while stalled");

    a_one_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second pair taken while one is in flight");

    a_no_force: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_pair_regime == REG_NONE || o_pair_regime == REG_FAULT)
            |-> o_pair_force_x == 0 && o_pair_force_y == 0 && o_pair_force_z == 0)
        else $error("force reported for a pair without interaction");

    a_totals: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_total_valid
            |-> o_total_force_x == 0 && o_total_force_y == 0 && o_total_force_z == 0)
        else $error("totals reported on a pair not marked last");

endmodule

bind particle_cohesive_force pcf_check u_pcf_check (.*);
